// ===== rtl/assert_macros.svh =====
// assertion macros shared by the framer modules
// no dependencies; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define JCPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define JCPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/jcpf_pkg.sv =====
// frame constants, command types and byte/crc helpers for the framer
// no dependencies; used by every framer module
`timescale 1ns / 1ps
`default_nettype none

package jcpf_pkg;

  localparam int FRAME_LEN       = 20;
  localparam int IDX_W           = $clog2(FRAME_LEN);
  localparam int HDR_LEN         = 18;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  SYNC_BYTE   = 8'h42;
  localparam logic [7:0]  ADDR_BYTE   = 8'd10;
  localparam logic [15:0] PAYLOAD_LEN = 16'd13;
  localparam logic [7:0]  PKT_ID      = 8'h1d;
  localparam logic [7:0]  MODE_IDLE   = 8'd0;
  localparam logic [7:0]  MODE_JOINT  = 8'd2;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(HDR_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [1:0]  link;
    logic        joint_pos;
    logic [31:0] target_a;
    logic [31:0] target_b;
    logic [31:0] target_c;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // one byte of crc-16 ccitt, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    logic [7:0]  s;
    c = crc_in;
    s = d;
    for (int b = 0; b < 8; b++) begin
      if (s[7] ^ c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
      s = {s[6:0], 1'b0};
    end
    return c;
  endfunction

  // bytes 0..17 of the frame
  function automatic logic [7:0] hdr_byte(input cmd_t cmd, input logic [IDX_W-1:0] idx);
    logic [HDR_LEN*8-1:0] h;
    h = {cmd.target_c, cmd.target_b, cmd.target_a,
         (cmd.joint_pos ? MODE_JOINT : MODE_IDLE), PKT_ID,
         PAYLOAD_LEN[15:8], PAYLOAD_LEN[7:0], ADDR_BYTE, SYNC_BYTE};
    return h[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jcpf_if.sv =====
// command and frame byte channel interfaces, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface jcpf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel_index;
  logic [1:0]  mode_code;
  logic [31:0] target_a;
  logic [31:0] target_b;
  logic [31:0] target_c;

  modport source (output valid, channel_index, mode_code, target_a, target_b, target_c,
                  input ready);
  modport sink   (input valid, channel_index, mode_code, target_a, target_b, target_c,
                  output ready);
endinterface

interface jcpf_byte_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_select;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, link_select, frame_byte, frame_end, input ready);
  modport sink   (input valid, link_select, frame_byte, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/joint_command_packet_framer.sv =====
// channel   dir  handshake     payload
// in_ch     in   valid/ready   channel_index, mode_code, target_a/b/c
// out_ch    out  valid/ready   link_select, frame_byte, frame_end
//
// a good command becomes 20 bytes, one per cycle while out_ch is ready
// the byte sequencer in the back stage paces the output; frames run back to back
// a command passes the front register and the queue before its first byte enters the output register
// a command with a bad link or mode is dropped in the front stage
// synchronous active-low reset empties the front stage, the queue and the output register
// depends on jcpf_pkg, jcpf_if, jcpf_front, jcpf_queue, jcpf_back
`timescale 1ns / 1ps
`default_nettype none

module joint_command_packet_framer #(
  parameter int QUEUE_DEPTH = jcpf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  jcpf_cmd_if.sink    in_ch,
  jcpf_byte_if.source out_ch
);
  import jcpf_pkg::*;

  cmd_slot_t push;
  cmd_slot_t head;
  logic      q_ready;
  logic      pop;

  jcpf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (push)
  );

  jcpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .head       (head),
    .pop        (pop)
  );

  jcpf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/jcpf_front.sv =====
// front stage: takes commands, drops bad link or mode, zeroes idle targets
// depends on jcpf_pkg and jcpf_cmd_if
`timescale 1ns / 1ps
`default_nettype none

module jcpf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  jcpf_cmd_if.sink               in_ch,
  input  wire logic              q_ready,
  output jcpf_pkg::cmd_slot_t    push
);
  import jcpf_pkg::*;

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept, cmd_ok;

  assign in_ch.ready = !valid_r || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd_ok      = !in_ch.channel_index[2] && !in_ch.mode_code[1];

  always_comb begin
    cmd_nxt           = cmd_r;
    cmd_nxt.link      = in_ch.channel_index[1:0];
    cmd_nxt.joint_pos = in_ch.mode_code[0];
    cmd_nxt.target_a  = in_ch.mode_code[0] ? in_ch.target_a : '0;
    cmd_nxt.target_b  = in_ch.mode_code[0] ? in_ch.target_b : '0;
    cmd_nxt.target_c  = in_ch.mode_code[0] ? in_ch.target_c : '0;
    if (accept) begin
      valid_nxt = cmd_ok;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign push.valid = valid_r;
  assign push.cmd   = cmd_r;

  `include "assert_macros.svh"

  // a held command is never dropped while the queue is full
  `JCPF_ASSERT(a_front_hold, valid_r && !q_ready |=> valid_r && $stable(cmd_r),
               "front command lost while queue full")

endmodule

`default_nettype wire

// ===== rtl/jcpf_queue.sv =====
// short command queue between front and back
// depends on jcpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module jcpf_queue #(
  parameter int DEPTH = jcpf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jcpf_pkg::cmd_slot_t push,
  output logic                   push_ready,
  output jcpf_pkg::cmd_slot_t    head,
  input  wire logic              pop
);
  import jcpf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  `include "assert_macros.svh"

  `JCPF_ASSERT(a_queue_bound, count_r <= CW'(DEPTH), "queue count above depth")
  `JCPF_ASSERT(a_queue_pop_empty, pop |-> count_r != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/jcpf_back.sv =====
// back stage: walks the 20 frame bytes of the head command, running crc
// depends on jcpf_pkg and jcpf_byte_if
`timescale 1ns / 1ps
`default_nettype none

module jcpf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jcpf_pkg::cmd_slot_t head,
  output logic                   pop,
  jcpf_byte_if.source            out_ch
);
  import jcpf_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_link_r;
  logic [7:0]       out_byte_r;
  logic             out_end_r;
  logic             load, last;
  logic [7:0]       cur_byte;

  assign load = head.valid && (!out_valid_r || out_ch.ready);
  assign last = (idx_r == IDX_LAST);
  assign pop  = load && last;

  always_comb begin
    if (idx_r < IDX_CRC_LO) begin
      cur_byte = hdr_byte(head.cmd, idx_r);
    end else if (idx_r == IDX_CRC_LO) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = crc_r[15:8];
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (last) begin
        idx_nxt = '0;
        crc_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r < IDX_CRC_LO) begin
          crc_nxt = crc_byte(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_link_r <= head.cmd.link;
      out_byte_r <= cur_byte;
      out_end_r  <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.link_select = out_link_r;
  assign out_ch.frame_byte  = out_byte_r;
  assign out_ch.frame_end   = out_end_r;

  `include "assert_macros.svh"

  `JCPF_ASSERT(a_back_end_wrap, out_valid_r && out_end_r |-> idx_r == '0 && crc_r == '0,
               "frame end shown without counter wrap")
  `JCPF_ASSERT(a_back_idx_range, idx_r <= IDX_LAST, "byte counter out of range")
  `JCPF_ASSERT(a_back_mid_frame, idx_r != '0 |-> head.valid, "command left mid frame")

endmodule

`default_nettype wire
